// File: hdl/hhmm_pkg.sv
// ----------------------------------------------------------------------------
// hhmm_pkg
// Shared types, constants and decode functions for the 24-hour clock and its
// four-digit multiplexed seven-segment display.
// ----------------------------------------------------------------------------
`default_nettype none

package hhmm_pkg;

   localparam int unsigned PERIOD_WIDTH = 5;
   localparam logic [PERIOD_WIDTH-1:0] SAMPLE_PERIOD_RESET = 5'd20;

   localparam logic [5:0] SEC_LAST  = 6'd59;
   localparam logic [5:0] MIN_LAST  = 6'd59;
   localparam logic [4:0] HOUR_LAST = 5'd23;

   typedef enum logic {
      REQ_SECOND  = 1'b0,
      REQ_REFRESH = 1'b1
   } req_kind_type;

   localparam logic [1:0] DIGIT_MIN_ONES  = 2'd0;
   localparam logic [1:0] DIGIT_MIN_TENS  = 2'd1;
   localparam logic [1:0] DIGIT_HOUR_ONES = 2'd2;
   localparam logic [1:0] DIGIT_HOUR_TENS = 2'd3;

   localparam int unsigned BTN_RESET = 0;
   localparam int unsigned BTN_PAUSE = 1;

   // active-low patterns, segment a in bit 0, decimal point off
   localparam logic [7:0] SEG_TABLE [10] = '{
      8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90
   };

   // actions raised by a button sample, handed to the time counter
   typedef struct packed {
      logic clear_time;
      logic toggle_run;
   } sample_ctrl_type;

   typedef struct packed {
      logic [3:0] tens;
      logic [3:0] ones;
   } digits_type;

   // decimal split of a value below 64 by a compare ladder
   function automatic digits_type split_digits(input logic [5:0] value);
      digits_type d;
      logic [5:0] rem;
      d.tens = 4'd0;
      rem    = value;
      priority if (value >= 6'd60) begin
         d.tens = 4'd6; rem = value - 6'd60;
      end else if (value >= 6'd50) begin
         d.tens = 4'd5; rem = value - 6'd50;
      end else if (value >= 6'd40) begin
         d.tens = 4'd4; rem = value - 6'd40;
      end else if (value >= 6'd30) begin
         d.tens = 4'd3; rem = value - 6'd30;
      end else if (value >= 6'd20) begin
         d.tens = 4'd2; rem = value - 6'd20;
      end else if (value >= 6'd10) begin
         d.tens = 4'd1; rem = value - 6'd10;
      end else begin
         d.tens = 4'd0; rem = value;
      end
      d.ones = rem[3:0];
      return d;
   endfunction

   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      if (digit <= 4'd9) begin
         pat = SEG_TABLE[digit];
      end else begin
         pat = 8'hff;
      end
      return pat;
   endfunction

endpackage

`default_nettype wire

// File: hdl/hhmm_time.sv
// ----------------------------------------------------------------------------
// hhmm_time
// Seconds, minutes and hours counters with run flag and seconds LED.
// ----------------------------------------------------------------------------
`default_nettype none

module hhmm_time (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     sec_tick,
   input  wire hhmm_pkg::sample_ctrl_type ctrl,
   output logic [5:0]                    minutes,
   output logic [4:0]                    hours,
   output logic                          seconds_led
);
   import hhmm_pkg::*;

   logic [5:0] seconds_ff, seconds_in;
   logic [5:0] minutes_ff, minutes_in;
   logic [4:0] hours_ff,   hours_in;
   logic       running_ff, running_in;
   logic       sec_led_ff, sec_led_in;

   always_comb begin
      seconds_in = seconds_ff;
      minutes_in = minutes_ff;
      hours_in   = hours_ff;
      running_in = running_ff;
      sec_led_in = sec_led_ff;
      // reset button wins over pause
      priority if (ctrl.clear_time) begin
         seconds_in = '0;
         minutes_in = '0;
         hours_in   = '0;
      end else if (ctrl.toggle_run) begin
         running_in = ~running_ff;
      end else if (sec_tick && running_ff) begin
         sec_led_in = ~sec_led_ff;
         if (seconds_ff >= SEC_LAST) begin
            seconds_in = '0;
            if (minutes_ff >= MIN_LAST) begin
               minutes_in = '0;
               hours_in   = (hours_ff >= HOUR_LAST) ? 5'd0 : hours_ff + 5'd1;
            end else begin
               minutes_in = minutes_ff + 6'd1;
            end
         end else begin
            seconds_in = seconds_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seconds_ff <= '0;
         minutes_ff <= '0;
         hours_ff   <= '0;
         running_ff <= 1'b1;
         sec_led_ff <= 1'b0;
      end else begin
         seconds_ff <= seconds_in;
         minutes_ff <= minutes_in;
         hours_ff   <= hours_in;
         running_ff <= running_in;
         sec_led_ff <= sec_led_in;
      end
   end

   assign minutes     = minutes_ff;
   assign hours       = hours_ff;
   assign seconds_led = sec_led_ff;

   a_sec_range: assert property (@(posedge clock) disable iff (reset)
      seconds_ff <= SEC_LAST) else $error("seconds out of range");
   a_min_range: assert property (@(posedge clock) disable iff (reset)
      minutes_ff <= MIN_LAST) else $error("minutes out of range");
   a_hour_range: assert property (@(posedge clock) disable iff (reset)
      hours_ff <= HOUR_LAST) else $error("hours out of range");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear_time |=> (seconds_ff == 6'd0) && (minutes_ff == 6'd0)
                          && (hours_ff == 5'd0))
      else $error("time not cleared after reset button");

endmodule

`default_nettype wire

// File: hdl/hhmm_disp.sv
// ----------------------------------------------------------------------------
// hhmm_disp
// Digit multiplexer, segment latch, button sampling and blink LED.
// ----------------------------------------------------------------------------
`default_nettype none

module hhmm_disp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  refresh_tick,
   input  wire logic [1:0]                            buttons,
   input  wire logic [hhmm_pkg::PERIOD_WIDTH-1:0]     sample_period,
   input  wire logic [5:0]                            minutes,
   input  wire logic [4:0]                            hours,
   output hhmm_pkg::sample_ctrl_type                  ctrl,
   output logic [7:0]                                 segments,
   output logic [3:0]                                 digit_enable,
   output logic                                       blink_led,
   output logic                                       button_led
);
   import hhmm_pkg::*;

   logic [1:0]              digit_idx_ff;
   logic [PERIOD_WIDTH-1:0] refresh_cnt_ff, refresh_cnt_in;
   logic [7:0]              seg_ff, seg_in;
   logic [3:0]              digit_en_ff;
   logic                    blink_ff, button_led_ff, button_led_in;
   logic                    sample_hit;
   logic [PERIOD_WIDTH-1:0] cnt_inc;
   digits_type              min_digits, hour_digits;
   logic [3:0]              digit_val;

   assign min_digits  = split_digits(minutes);
   assign hour_digits = split_digits({1'b0, hours});

   always_comb begin
      unique case (digit_idx_ff)
         DIGIT_MIN_ONES:  digit_val = min_digits.ones;
         DIGIT_MIN_TENS:  digit_val = min_digits.tens;
         DIGIT_HOUR_ONES: digit_val = hour_digits.ones;
         DIGIT_HOUR_TENS: digit_val = hour_digits.tens;
         default:         digit_val = 4'd0;
      endcase
   end

   assign seg_in = seg_pattern(digit_val);

   // counter compared after the increment; wraps freely at 32
   assign cnt_inc        = refresh_cnt_ff + PERIOD_WIDTH'(1);
   assign sample_hit     = refresh_tick && (cnt_inc == sample_period);
   assign refresh_cnt_in = sample_hit ? '0 : cnt_inc;

   always_comb begin
      ctrl          = '0;
      button_led_in = 1'b0;
      if (sample_hit) begin
         priority if (buttons[BTN_RESET]) begin
            ctrl.clear_time = 1'b1;
            button_led_in   = 1'b1;
         end else if (buttons[BTN_PAUSE]) begin
            ctrl.toggle_run = 1'b1;
            button_led_in   = 1'b1;
         end else begin
            button_led_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_idx_ff   <= DIGIT_MIN_ONES;
         refresh_cnt_ff <= '0;
         seg_ff         <= '0;
         digit_en_ff    <= '0;
         blink_ff       <= 1'b0;
         button_led_ff  <= 1'b0;
      end else if (refresh_tick) begin
         digit_idx_ff   <= digit_idx_ff + 2'd1;
         refresh_cnt_ff <= refresh_cnt_in;
         seg_ff         <= seg_in;
         digit_en_ff    <= 4'b0001 << digit_idx_ff;
         if (sample_hit) begin
            blink_ff      <= ~blink_ff;
            button_led_ff <= button_led_in;
         end
      end
   end

   assign segments     = seg_ff;
   assign digit_enable = digit_en_ff;
   assign blink_led    = blink_ff;
   assign button_led   = button_led_ff;

endmodule

`default_nettype wire

// File: hdl/hhmm_clock_seven_segment_mux.sv
// ----------------------------------------------------------------------------
// hhmm_clock_seven_segment_mux
// 24-hour clock driving a four-digit multiplexed seven-segment display.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one item per event; req_type low is a one-second tick,
//   high a display refresh tick carrying the two button pins.
//   rsp_ channel: exactly one item per request, holding the segment pattern
//   (active low), the one-hot digit enable and the three LEDs after the event.
//   csr_ port: writes sample_period, the number of refresh ticks between
//   button samples and blink toggles; write only while no item is in flight.
// Result: the time and display registers are updated at the accepting edge
// and double as the result register, valid in the cycle after acceptance.
// Throughput: one item per cycle, set by the single register stage.
// A stalled receiver holds the result; req_ready is low only while a result
// is waiting and rsp_ready is low.
// Reset: time 00:00, clock running, display blank (no digit enabled; all latches zero),
// sample_period 20.
// ----------------------------------------------------------------------------
`default_nettype none

module hhmm_clock_seven_segment_mux (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_type,
   input  wire logic [1:0]                        req_button_pins,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [7:0]                             rsp_segments,
   output logic [3:0]                             rsp_digit_enable,
   output logic                                   rsp_seconds_led,
   output logic                                   rsp_blink_led,
   output logic                                   rsp_button_led,
   input  wire logic                              csr_write_enable,
   input  wire logic [hhmm_pkg::PERIOD_WIDTH-1:0] csr_write_data
);
   import hhmm_pkg::*;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PERIOD_WIDTH-1:0] period_ff;
   logic                    accept;
   logic                    sec_tick, refresh_tick;
   sample_ctrl_type         ctrl;
   logic [5:0]              minutes;
   logic [4:0]              hours;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign sec_tick     = accept && (req_type == REQ_SECOND);
   assign refresh_tick = accept && (req_type == REQ_REFRESH);
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         period_ff    <= SAMPLE_PERIOD_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            period_ff <= csr_write_data;
         end
      end
   end

   hhmm_time u_time (
      .clock       (clock),
      .reset       (reset),
      .sec_tick    (sec_tick),
      .ctrl        (ctrl),
      .minutes     (minutes),
      .hours       (hours),
      .seconds_led (rsp_seconds_led)
   );

   hhmm_disp u_disp (
      .clock         (clock),
      .reset         (reset),
      .refresh_tick  (refresh_tick),
      .buttons       (req_button_pins),
      .sample_period (period_ff),
      .minutes       (minutes),
      .hours         (hours),
      .ctrl          (ctrl),
      .segments      (rsp_segments),
      .digit_enable  (rsp_digit_enable),
      .blink_led     (rsp_blink_led),
      .button_led    (rsp_button_led)
   );

   assign rsp_valid = rsp_valid_ff;

   a_digit_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(rsp_digit_enable)) else $error("digit enable not one-hot");
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff) else $error("accepted item gave no result");

endmodule

`default_nettype wire
